// ===== hw/rtl/lzd_pkg.sv =====
// Types and constants shared by the LZ bit-stream decompressor.
// No dependencies.
package lzd_pkg;

  localparam logic [1:0] OP_FEED  = 2'd0;
  localparam logic [1:0] OP_PULL  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [2:0] ST_BYTE   = 3'd0;
  localparam logic [2:0] ST_ACCEPT = 3'd1;
  localparam logic [2:0] ST_REFUSE = 3'd2;
  localparam logic [2:0] ST_NEED   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;
  localparam logic [2:0] ST_BADHDR = 3'd5;
  localparam logic [2:0] ST_BADPAD = 3'd6;
  localparam logic [2:0] ST_BADREF = 3'd7;

  localparam logic [20:0] BIAS_C0 = 21'd1;
  localparam logic [20:0] BIAS_C1 = 21'd65;
  localparam logic [20:0] BIAS_C2 = 21'd577;
  localparam logic [20:0] BIAS_C3 = 21'd4673;
  localparam logic [19:0] END_MARK = 20'hFFFFF;
  localparam logic [7:0]  PAD_BYTE = 8'hFF;

  localparam int unsigned NEED_OPEN  = 49;
  localparam int unsigned NEED_ENDED = 33;

  typedef enum logic [2:0] {
    PH_AWAIT  = 3'd0,
    PH_DECODE = 3'd1,
    PH_DRAIN  = 3'd2,
    PH_FINAL  = 3'd3,
    PH_BADHDR = 3'd4,
    PH_BADREF = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       byte_is_last;
  } lzd_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic [15:0] produced_count;
  } lzd_out_t;

  // One parsed code from the head of the bit window
  typedef struct packed {
    logic        is_lit;
    logic [7:0]  lit;
    logic        end_code;
    logic [20:0] copy_dist;
    logic [13:0] len;
    logic [5:0]  drop;
  } lzd_code_t;

endpackage

// ===== hw/rtl/lzd_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/lzd_parse.sv =====
// Code parser: literal, back-reference distance class and gamma length.
// Depends on lzd_pkg.
module lzd_parse
  import lzd_pkg::*;
(
  input  logic [63:0] win,
  output lzd_code_t   code
);

  logic [4:0]  used;
  logic [39:0] seg;
  logic [3:0]  rc;
  logic        run;
  logic [39:0] vs;
  logic [11:0] v;
  logic [12:0] mask;
  logic [1:0]  add;

  always_comb begin
    code.is_lit   = ~win[0];
    code.lit      = win[8:1];
    code.end_code = 1'b0;
    add           = 2'd1;
    priority if (!win[1]) begin
      code.copy_dist = 21'(win[7:2]) + BIAS_C0;
      used           = 5'd8;
    end else if (!win[2]) begin
      code.copy_dist = 21'(win[11:3]) + BIAS_C1;
      used           = 5'd12;
    end else if (!win[3]) begin
      code.copy_dist = 21'(win[15:4]) + BIAS_C2;
      used           = 5'd16;
    end else begin
      code.copy_dist = 21'(win[23:4]) + BIAS_C3;
      code.end_code  = (win[23:4] == END_MARK);
      used           = 5'd24;
      add            = 2'd2;
    end
    seg = 40'(win >> used);
    rc  = '0;
    run = 1'b1;
    for (int i = 0; i < 12; i++) begin
      if (run && seg[i]) begin
        rc = rc + 4'd1;
      end else begin
        run = 1'b0;
      end
    end
    vs       = seg >> (rc + 4'd1);
    mask     = (13'd1 << rc) - 13'd1;
    v        = vs[11:0] & mask[11:0];
    code.len = 14'(v) + 14'(13'd1 << rc) + 14'(add);
    code.drop = 6'(used) + {1'b0, rc, 1'b0} + 6'd1;
  end

endmodule

// ===== hw/rtl/lz_bitstream_decompressor.sv =====
// Top level of the streaming LZ77 bit-stream decompressor.
// Depends on lzd_pkg, lzd_parse and lzd_ram.
//
//  channel  | signals                          | meaning
//  ---------+----------------------------------+-------------------------------
//  in       | in_valid, in_ready, in_data      | feed / pull / start transfer
//  out      | out_valid, out_ready, out_data   | one status result per item
//  cfg      | cfg_wr_en, cfg_wr_data           | target_size write
//
// One item per cycle while the output is not stalled. Stage 0 parses
// the code at the head of the bit window, updates all stream state and
// issues the history read; stage 1 is the output register, where the
// copied byte arrives from the RAM. History is written as a result
// leaves stage 1; a read of the same entry on that edge takes the byte
// from a forwarding register (distance one). A result is registered in
// stage 1 when its input is taken. Synchronous reset; no clearing pass,
// history is only ever read where this stream wrote it. A stalled output
// holds the result and the RAM read data; input is taken while the output drains.
module lz_bitstream_decompressor
  import lzd_pkg::*;
#(
  parameter int HISTORY_DEPTH   = 65536,
  parameter int BIT_WINDOW_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lzd_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output lzd_out_t    out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int W  = BIT_WINDOW_BITS;
  localparam int HW = $clog2(W + 1);
  localparam int DX = ((AW > 21) ? AW : 21) + 1;  // signed difference width

  // stream state
  logic [15:0]   target_size;
  logic [W-1:0]  bit_window, bit_window_next;
  logic [HW-1:0] bits_held, bits_held_next;
  logic [3:0]    hdr_seen, hdr_seen_next;
  logic [2:0]    ff_run, ff_run_next;
  logic          ended, ended_next;
  logic [13:0]   run_rem, run_rem_next;
  logic [20:0]   run_dist, run_dist_next;
  logic [15:0]   produced, produced_next;
  logic [AW-1:0] wp, wp_next;
  phase_t        phase, phase_next;

  // stage 1 (output register)
  logic          s1_valid;
  logic [2:0]    s1_status, status_c;
  logic [15:0]   s1_count;
  logic          s1_copy, copy_c;
  logic [7:0]    s1_lit;
  logic [AW-1:0] s1_addr;
  logic          s1_fwd;
  logic [7:0]    fwd_byte;
  logic [7:0]    s1_byte;
  logic [7:0]    ram_q;

  lzd_code_t     code;
  logic          load, leave;
  logic          at_target, has_run, bits_ok, window_full, final_ok;
  logic          ref_bad;
  logic [2:0]    settle_st, final_st;
  logic [20:0]   rd_dist;
  logic [DX-1:0] diff;
  logic [AW-1:0] rd_addr;
  logic [16:0]   end_sum;
  logic [W-1:0]  push_bits;
  logic [HW-1:0] drop_n;

  assign leave    = s1_valid && out_ready;
  assign in_ready = !s1_valid || out_ready;
  assign load     = in_valid && in_ready;

  lzd_parse u_parse (
    .win  (bit_window[63:0]),
    .code (code)
  );

  // shared conditions
  assign at_target   = (produced >= target_size);
  assign has_run     = (run_rem != '0);
  assign bits_ok     = ended ? (bits_held >= HW'(NEED_ENDED)) : (bits_held >= HW'(NEED_OPEN));
  assign window_full = (32'(bits_held) + 32'd8 > 32'(W));
  assign final_ok    = (ff_run >= 3'd5) && (hdr_seen >= 4'd8);
  assign final_st    = final_ok ? ST_DONE : ST_BADPAD;
  assign settle_st   = ended ? final_st : ST_NEED;
  assign end_sum     = {1'b0, produced} + 17'(code.len);
  assign ref_bad     = (end_sum > {1'b0, target_size}) || (code.copy_dist > 21'(produced))
                       || (32'(code.copy_dist) > 32'(HISTORY_DEPTH));
  assign push_bits   = W'(in_data.data_byte) << bits_held;
  assign drop_n      = HW'(code.drop);

  // history read address: write pointer minus distance, wrapped
  assign rd_dist = has_run ? run_dist : code.copy_dist;
  always_comb begin
    diff = DX'(wp) - DX'(rd_dist);
    if (diff[DX-1]) begin
      diff = diff + DX'(HISTORY_DEPTH);
    end
    rd_addr = diff[AW-1:0];
  end

  // result of the item (outputs)
  always_comb begin
    copy_c     = 1'b0;
    status_c   = ST_REFUSE;
    unique case (in_data.operation)
      OP_FEED: begin
        unique case (phase)
          PH_AWAIT:  status_c = (in_data.data_byte != 8'd0) ? ST_BADHDR : ST_ACCEPT;
          PH_DECODE: status_c = (ended || window_full) ? ST_REFUSE : ST_ACCEPT;
          PH_DRAIN:  status_c = ST_ACCEPT;
          PH_BADHDR: status_c = ST_BADHDR;
          PH_BADREF: status_c = ST_BADREF;
          default:   status_c = ST_REFUSE;
        endcase
      end
      OP_PULL: begin
        unique case (phase)
          PH_DECODE: begin
            priority if (at_target) begin
              status_c = settle_st;
            end else if (has_run) begin
              status_c = ST_BYTE;
              copy_c   = 1'b1;
            end else if (!bits_ok) begin
              status_c = settle_st;
            end else if (code.is_lit) begin
              status_c   = ST_BYTE;
            end else if (code.end_code) begin
              status_c = settle_st;
            end else if (ref_bad) begin
              status_c = ST_BADREF;
            end else begin
              status_c = ST_BYTE;
              copy_c   = 1'b1;
            end
          end
          PH_FINAL:  status_c = final_st;
          PH_BADHDR: status_c = ST_BADHDR;
          PH_BADREF: status_c = ST_BADREF;
          default:   status_c = ST_NEED;
        endcase
      end
      OP_START: status_c = ST_ACCEPT;
      default:  status_c = ST_REFUSE;
    endcase
  end

  // next stream state
  always_comb begin
    bit_window_next = bit_window;
    bits_held_next  = bits_held;
    hdr_seen_next   = hdr_seen;
    ff_run_next     = ff_run;
    ended_next      = ended;
    run_rem_next    = run_rem;
    run_dist_next   = run_dist;
    produced_next   = produced;
    wp_next         = wp;
    phase_next      = phase;
    unique case (in_data.operation)
      OP_FEED: begin
        unique case (phase)
          PH_AWAIT, PH_DECODE, PH_DRAIN: begin
            if ((phase == PH_AWAIT && in_data.data_byte != 8'd0)) begin
              phase_next = PH_BADHDR;
            end else if (!(phase == PH_DECODE && (ended || window_full))) begin
              hdr_seen_next = (hdr_seen == 4'd15) ? hdr_seen : hdr_seen + 4'd1;
              if (in_data.data_byte == PAD_BYTE) begin
                ff_run_next = (ff_run == 3'd7) ? ff_run : ff_run + 3'd1;
              end else begin
                ff_run_next = '0;
              end
              if (in_data.byte_is_last) begin
                ended_next = 1'b1;
              end
              unique case (phase)
                PH_AWAIT: phase_next = PH_DECODE;
                PH_DECODE: begin
                  bit_window_next = bit_window | push_bits;
                  bits_held_next  = bits_held + HW'(8);
                end
                default: begin
                  if (ended || in_data.byte_is_last) begin
                    phase_next = PH_FINAL;
                  end
                end
              endcase
            end
          end
          default: ;
        endcase
      end
      OP_PULL: begin
        if (phase == PH_DECODE) begin
          priority if (at_target || (!has_run && ((!bits_ok && ended)
                       || (bits_ok && !code.is_lit && code.end_code)))) begin
            run_rem_next = '0;
            phase_next   = ended ? PH_FINAL : PH_DRAIN;
          end else if (!has_run && !bits_ok) begin
            // too few bits before the last byte: wait for more input
            phase_next = phase;
          end else if (!has_run && !code.is_lit && ref_bad) begin
            bit_window_next = bit_window >> drop_n;
            bits_held_next  = (bits_held > drop_n) ? bits_held - drop_n : '0;
            run_rem_next    = '0;
            phase_next      = PH_BADREF;
          end else begin
            if (!has_run) begin
              bit_window_next = bit_window >> (code.is_lit ? HW'(9) : drop_n);
              if (code.is_lit) begin
                bits_held_next = (bits_held > HW'(9)) ? bits_held - HW'(9) : '0;
              end else begin
                bits_held_next = (bits_held > drop_n) ? bits_held - drop_n : '0;
                run_dist_next  = code.copy_dist;
                run_rem_next   = code.len - 14'd1;
              end
            end else begin
              run_rem_next = run_rem - 14'd1;
            end
            produced_next = produced + 16'd1;
            wp_next       = (32'(wp) == HISTORY_DEPTH - 1) ? '0 : wp + AW'(1);
            if (produced_next >= target_size) begin
              run_rem_next = '0;
              phase_next   = ended ? PH_FINAL : PH_DRAIN;
            end
          end
        end
      end
      OP_START: begin
        bit_window_next = '0;
        bits_held_next  = '0;
        hdr_seen_next   = '0;
        ff_run_next     = '0;
        ended_next      = 1'b0;
        run_rem_next    = '0;
        run_dist_next   = '0;
        produced_next   = '0;
        wp_next         = '0;
        phase_next      = PH_AWAIT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_size <= 16'hFFFF;
      bit_window  <= '0;
      bits_held   <= '0;
      hdr_seen    <= '0;
      ff_run      <= '0;
      ended       <= 1'b0;
      run_rem     <= '0;
      run_dist    <= '0;
      produced    <= '0;
      wp          <= '0;
      phase       <= PH_AWAIT;
      s1_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        target_size <= cfg_wr_data;
      end
      if (load) begin
        bit_window <= bit_window_next;
        bits_held  <= bits_held_next;
        hdr_seen   <= hdr_seen_next;
        ff_run     <= ff_run_next;
        ended      <= ended_next;
        run_rem    <= run_rem_next;
        run_dist   <= run_dist_next;
        produced   <= produced_next;
        wp         <= wp_next;
        phase      <= phase_next;
        s1_valid   <= 1'b1;
      end else if (leave) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (load) begin
      s1_status <= status_c;
      s1_count  <= produced_next;
      s1_copy   <= copy_c;
      s1_lit    <= code.lit;
      s1_addr   <= wp;
      // same entry written as it is read: take the leaving byte
      s1_fwd    <= leave && (s1_status == ST_BYTE) && (s1_addr == rd_addr);
      fwd_byte  <= s1_byte;
    end
  end

  assign s1_byte = s1_copy ? (s1_fwd ? fwd_byte : ram_q) : s1_lit;

  lzd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (leave && (s1_status == ST_BYTE)),
    .wr_addr (s1_addr),
    .wr_data (s1_byte),
    .rd_en   (load),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  assign out_valid               = s1_valid;
  assign out_data.status         = s1_status;
  assign out_data.out_byte       = (s1_status == ST_BYTE) ? s1_byte : 8'd0;
  assign out_data.produced_count = s1_count;

endmodule
